/* hdl/acfh_pkg.sv */
// ----------------------------------------------------------------------------
// acfh_pkg
// Shared types and character codes of the ascii command frame handler.
// ----------------------------------------------------------------------------
`default_nettype none

package acfh_pkg;

    // characters used by the parser and the reply generator
    localparam logic [7:0] CH_HASH    = 8'h23;  // '#'
    localparam logic [7:0] CH_BANG    = 8'h21;  // '!'
    localparam logic [7:0] CH_NL      = 8'h0A;  // newline
    localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
    localparam logic [7:0] CH_UPPER_E = 8'h45;  // 'E'
    localparam logic [7:0] CH_LOWER_O = 8'h6F;  // 'o'
    localparam logic [7:0] CH_LOWER_F = 8'h66;  // 'f'
    localparam logic [7:0] CH_LOWER_S = 8'h73;  // 's'
    localparam logic [7:0] CH_LOWER_I = 8'h69;  // 'i'
    localparam logic [7:0] CH_LOWER_C = 8'h63;  // 'c'
    localparam logic [7:0] CH_UPPER_C = 8'h43;  // 'C'
    localparam logic [7:0] CH_UPPER_M = 8'h4D;  // 'M'
    localparam logic [7:0] CH_UPPER_S = 8'h53;  // 'S'

    localparam int TEMP_W   = 10;
    localparam logic [TEMP_W-1:0] TEMP_MAX = 10'd999;

    // reply kinds queued between parser and reply generator
    typedef logic [2:0] reply_kind_t;
    localparam reply_kind_t KIND_TEMP  = 3'd0;
    localparam reply_kind_t KIND_ACK   = 3'd1;
    localparam reply_kind_t KIND_ERR_F = 3'd2;
    localparam reply_kind_t KIND_ERR_S = 3'd3;
    localparam reply_kind_t KIND_ERR_I = 3'd4;

    typedef struct packed {
        reply_kind_t       kind;
        logic [TEMP_W-1:0] temp;
    } reply_desc_t;

    // reply queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

endpackage

`default_nettype wire

/* hdl/acfh_parse.sv */
// ----------------------------------------------------------------------------
// acfh_parse
// Frame parser: collects received characters, checks framing and checksum,
// and hands one reply descriptor per completed frame to the reply queue.
// ----------------------------------------------------------------------------
`default_nettype none

module acfh_parse #(
    parameter int MAX_FRAME = 63,
    parameter int MAX_DATA  = 30
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic [7:0]           rx_byte,
    input  wire logic [acfh_pkg::TEMP_W-1:0] current_temp,
    output logic                      push,
    output acfh_pkg::reply_desc_t     push_desc
);
    import acfh_pkg::*;

    localparam int LEN_W  = $clog2(MAX_FRAME + 1);
    localparam int CMP_W  = 10;
    localparam int DLIM   = MAX_DATA + 6;

    logic [LEN_W-1:0] len_reg, len_next, len_inc;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       tail_reg [3];
    logic [7:0]       tail_next [3];
    logic             zero_reg, zero_next;
    logic             open_frame;
    logic             complete;
    logic             bad;
    logic [7:0]       payload;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // decimal reading of the three checksum characters: blanks, one sign, digits
    function automatic logic cksum_ok(input logic [7:0] w0, input logic [7:0] w1,
                                      input logic [7:0] w2, input logic [7:0] want);
        logic [7:0] ch [3];
        logic [1:0] phase;
        logic [9:0] val;
        logic       neg;
        ch[0] = w0;
        ch[1] = w1;
        ch[2] = w2;
        phase = 2'd0;
        val   = '0;
        neg   = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (phase == 2'd0) begin
                if (is_blank(ch[i])) begin
                    phase = 2'd0;
                end
                else if (ch[i] == 8'h2B || ch[i] == 8'h2D) begin
                    neg   = (ch[i] == 8'h2D);
                    phase = 2'd1;
                end
                else if (is_digit(ch[i])) begin
                    val   = 10'(({4'd0, val} * 14'd10) + 14'(ch[i] - CH_ZERO));
                    phase = 2'd1;
                end
                else begin
                    phase = 2'd2;
                end
            end
            else if (phase == 2'd1) begin
                if (is_digit(ch[i])) begin
                    val = 10'(({4'd0, val} * 14'd10) + 14'(ch[i] - CH_ZERO));
                end
                else begin
                    phase = 2'd2;
                end
            end
        end
        if (neg && val != 10'd0) begin
            return 1'b0;
        end
        return val == {2'b00, want};
    endfunction

    assign open_frame = (len_reg != '0) || (rx_byte == CH_HASH);
    assign len_inc    = len_reg + LEN_W'(1);
    assign complete   = accept && open_frame &&
                        ((rx_byte == CH_BANG) || (len_inc >= LEN_W'(MAX_FRAME)));

    // on a frame closed by '!' the held bytes are the registered ones
    assign payload = sum_reg - tail_reg[0] - tail_reg[1] - tail_reg[2];
    assign bad     = zero_reg || (rx_byte != CH_BANG) || (len_inc < LEN_W'(6)) ||
                     (CMP_W'(len_inc) > CMP_W'(DLIM));

    always_comb
    begin
        len_next  = len_reg;
        cmd_next  = cmd_reg;
        sum_next  = sum_reg;
        zero_next = zero_reg;
        for (int i = 0; i < 3; i++) begin
            tail_next[i] = tail_reg[i];
        end
        if (accept && open_frame) begin
            if (complete) begin
                len_next  = '0;
                cmd_next  = '0;
                sum_next  = '0;
                zero_next = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    tail_next[i] = '0;
                end
            end
            else begin
                len_next = len_inc;
                if (rx_byte == 8'h00) begin
                    zero_next = 1'b1;
                end
                if (len_reg == LEN_W'(1)) begin
                    cmd_next = rx_byte;
                end
                if (len_reg != '0) begin
                    sum_next = sum_reg + rx_byte;
                end
                tail_next[0] = tail_reg[1];
                tail_next[1] = tail_reg[2];
                tail_next[2] = rx_byte;
            end
        end
    end

    always_comb
    begin
        push_desc.temp = (current_temp > TEMP_MAX) ? TEMP_MAX : current_temp;
        if (bad) begin
            push_desc.kind = KIND_ERR_F;
        end
        else if (!cksum_ok(tail_reg[0], tail_reg[1], tail_reg[2], payload)) begin
            push_desc.kind = KIND_ERR_S;
        end
        else if (cmd_reg == CH_UPPER_C) begin
            push_desc.kind = KIND_TEMP;
        end
        else if (cmd_reg == CH_UPPER_M || cmd_reg == CH_UPPER_S) begin
            push_desc.kind = KIND_ACK;
        end
        else begin
            push_desc.kind = KIND_ERR_I;
        end
    end

    assign push = complete;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            len_reg  <= '0;
            cmd_reg  <= '0;
            sum_reg  <= '0;
            zero_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                tail_reg[i] <= '0;
            end
        end
        else begin
            len_reg  <= len_next;
            cmd_reg  <= cmd_next;
            sum_reg  <= sum_next;
            zero_reg <= zero_next;
            for (int i = 0; i < 3; i++) begin
                tail_reg[i] <= tail_next[i];
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/acfh_fifo.sv */
// ----------------------------------------------------------------------------
// acfh_fifo
// Short queue of reply descriptors between parser and reply generator.
// ----------------------------------------------------------------------------
`default_nettype none

module acfh_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire acfh_pkg::reply_desc_t push_desc,
    input  wire logic                  pop,
    output acfh_pkg::reply_desc_t      pop_desc,
    output logic                       nonempty,
    output logic                       full
);
    import acfh_pkg::*;

    reply_desc_t         slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                do_push, do_pop;

    assign nonempty = (count_reg != '0);
    assign full     = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;
    assign pop_desc = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end
        else if (!do_push && do_pop) begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/acfh_reply.sv */
// ----------------------------------------------------------------------------
// acfh_reply
// Reply generator: turns one descriptor into its ascii reply, one character
// per cycle while the sink is ready, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module acfh_reply (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire acfh_pkg::reply_desc_t desc,
    input  wire logic                  desc_valid,
    output logic                       desc_pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 out_data,
    output logic                       out_last
);
    import acfh_pkg::*;

    // ('E' + code) mod 256 for the fixed replies, as three digits
    localparam logic [7:0] SUM_O = CH_UPPER_E + CH_LOWER_O;
    localparam logic [7:0] SUM_F = CH_UPPER_E + CH_LOWER_F;
    localparam logic [7:0] SUM_S = CH_UPPER_E + CH_LOWER_S;
    localparam logic [7:0] SUM_I = CH_UPPER_E + CH_LOWER_I;
    localparam logic [7:0] O_H = 8'(48 + (SUM_O / 100) % 10);
    localparam logic [7:0] O_T = 8'(48 + (SUM_O / 10) % 10);
    localparam logic [7:0] O_U = 8'(48 + SUM_O % 10);
    localparam logic [7:0] F_H = 8'(48 + (SUM_F / 100) % 10);
    localparam logic [7:0] F_T = 8'(48 + (SUM_F / 10) % 10);
    localparam logic [7:0] F_U = 8'(48 + SUM_F % 10);
    localparam logic [7:0] S_H = 8'(48 + (SUM_S / 100) % 10);
    localparam logic [7:0] S_T = 8'(48 + (SUM_S / 10) % 10);
    localparam logic [7:0] S_U = 8'(48 + SUM_S % 10);
    localparam logic [7:0] I_H = 8'(48 + (SUM_I / 100) % 10);
    localparam logic [7:0] I_T = 8'(48 + (SUM_I / 10) % 10);
    localparam logic [7:0] I_U = 8'(48 + SUM_I % 10);

    localparam logic [3:0] LAST_TEMP = 4'd9;
    localparam logic [3:0] LAST_CODE = 4'd7;

    logic              busy_reg;
    reply_kind_t       kind_reg;
    logic [TEMP_W-1:0] temp_reg;
    logic [3:0]        idx_reg;
    logic [3:0]        hun_reg;   // temperature hundreds
    logic [6:0]        rem_reg;   // temperature mod 100
    logic [3:0]        ten_reg;   // temperature tens
    logic [6:0]        cs_reg;    // reply checksum, at most 126
    logic [6:0]        crem_reg;  // reply checksum mod 100
    logic [3:0]        cten_reg;  // reply checksum tens
    logic              out_valid_reg;
    logic [7:0]        out_data_reg;
    logic              out_last_reg;

    logic              advance, at_last, load;
    logic [15:0]       hun_prod;
    logic [14:0]       ten_prod, cten_prod;
    logic [3:0]        ones, cones;
    logic              cs_hun;
    logic [7:0]        code_ch, dig_h, dig_t, dig_u;
    logic [7:0]        gen_byte;

    assign advance = busy_reg && (!out_valid_reg || out_ready);
    assign at_last = (idx_reg == ((kind_reg == KIND_TEMP) ? LAST_TEMP : LAST_CODE));
    assign load    = desc_valid && (!busy_reg || (advance && at_last));
    assign desc_pop = load;

    // decimal split by reciprocal multiply, exact over the ranges used here
    assign hun_prod  = 16'(temp_reg) * 16'd41;
    assign ten_prod  = 15'(rem_reg) * 15'd205;
    assign cten_prod = 15'(crem_reg) * 15'd205;
    assign ones      = 4'(rem_reg - 7'(ten_reg) * 7'd10);
    assign cones     = 4'(crem_reg - 7'(cten_reg) * 7'd10);
    assign cs_hun    = (cs_reg >= 7'd100);

    always_comb
    begin
        unique case (kind_reg)
            KIND_ACK:   begin code_ch = CH_LOWER_O; dig_h = O_H; dig_t = O_T; dig_u = O_U; end
            KIND_ERR_F: begin code_ch = CH_LOWER_F; dig_h = F_H; dig_t = F_T; dig_u = F_U; end
            KIND_ERR_S: begin code_ch = CH_LOWER_S; dig_h = S_H; dig_t = S_T; dig_u = S_U; end
            default:    begin code_ch = CH_LOWER_I; dig_h = I_H; dig_t = I_T; dig_u = I_U; end
        endcase
    end

    always_comb
    begin
        gen_byte = CH_NL;
        if (kind_reg == KIND_TEMP) begin
            case (idx_reg)
                4'd0:    gen_byte = CH_HASH;
                4'd1:    gen_byte = CH_LOWER_C;
                4'd2:    gen_byte = CH_ZERO + 8'(hun_reg);
                4'd3:    gen_byte = CH_ZERO + 8'(ten_reg);
                4'd4:    gen_byte = CH_ZERO + 8'(ones);
                4'd5:    gen_byte = CH_ZERO + 8'(cs_hun);
                4'd6:    gen_byte = CH_ZERO + 8'(cten_prod[14:11]);
                4'd7:    gen_byte = CH_ZERO + 8'(cones);
                4'd8:    gen_byte = CH_BANG;
                default: gen_byte = CH_NL;
            endcase
        end
        else begin
            case (idx_reg)
                4'd0:    gen_byte = CH_HASH;
                4'd1:    gen_byte = CH_UPPER_E;
                4'd2:    gen_byte = code_ch;
                4'd3:    gen_byte = dig_h;
                4'd4:    gen_byte = dig_t;
                4'd5:    gen_byte = dig_u;
                4'd6:    gen_byte = CH_BANG;
                default: gen_byte = CH_NL;
            endcase
        end
    end

    // digit registers, each filled on an earlier advance than the one sending its character
    always_ff @(posedge clk)
    begin
        if (load) begin
            kind_reg <= desc.kind;
            temp_reg <= desc.temp;
        end
        if (advance) begin
            case (idx_reg)
                4'd0:    hun_reg  <= hun_prod[15:12];
                4'd1:    rem_reg  <= 7'(temp_reg - 10'(hun_reg) * 10'd100);
                4'd2:    ten_reg  <= ten_prod[14:11];
                4'd4:    cs_reg   <= 7'(CH_LOWER_C) + 7'(hun_reg) + 7'(ten_reg) + 7'(ones);
                4'd5:    crem_reg <= cs_hun ? cs_reg - 7'd100 : cs_reg;
                4'd6:    cten_reg <= cten_prod[14:11];
                default: ;
            endcase
            out_data_reg <= gen_byte;
            out_last_reg <= at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (load) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (advance) begin
                if (at_last) begin
                    busy_reg <= 1'b0;
                end
                idx_reg <= idx_reg + 4'd1;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

/* hdl/ascii_command_frame_handler.sv */
// ----------------------------------------------------------------------------
// ascii_command_frame_handler
// Serial command frame parser with ascii reply generation.
// ----------------------------------------------------------------------------
// Received characters come in on the slave stream, one per transfer, and may
// arrive every cycle. Characters are dropped until '#' opens a frame; the
// frame closes at '!' or when it holds MAX_FRAME characters. A good frame is
// '#', a command, 0 to MAX_DATA data characters, three checksum characters
// and '!'; the checksum is read as a decimal number and must equal the byte
// sum of command and data mod 256. Each closed frame yields one reply on the
// master stream, one character per transfer, tlast on the closing newline:
// "#c" + temperature + checksum + "!" for C, "#Eo..." for M and S, and
// "#Ef...", "#Es..." or "#Ei..." for framing, checksum or command errors.
// The parser takes one character per cycle and queues a short descriptor per
// frame; the reply generator then sends 10 characters (C) or 8 characters
// (all others), one per cycle while the sink is ready. The parser only
// stalls when the four-entry reply queue is full. With the queue and the
// generator idle, the closing '!' pushes a descriptor into the queue, the
// generator loads it from there and registers the first reply character.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_command_frame_handler #(
    parameter int MAX_FRAME = 63,
    parameter int MAX_DATA  = 30
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // rx_byte[7:0], current_temp[17:8], zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // tx_byte[7:0]
    output logic             m_axis_tlast    // last
);
    import acfh_pkg::*;

    logic        in_xfer;       // input transfer this cycle
    logic        push;
    reply_desc_t push_desc;
    reply_desc_t pop_desc;
    logic        pop;
    logic        q_nonempty;
    logic        q_full;

    // the parser never runs into a full queue: input waits instead
    assign s_axis_tready = !q_full;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    acfh_parse #(
        .MAX_FRAME (MAX_FRAME),
        .MAX_DATA  (MAX_DATA)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_xfer),
        .rx_byte      (s_axis_tdata[7:0]),
        .current_temp (s_axis_tdata[17:8]),
        .push         (push),
        .push_desc    (push_desc)
    );

    // descriptor queue decouples parsing from reply output
    acfh_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .nonempty  (q_nonempty),
        .full      (q_full)
    );

    acfh_reply u_reply (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc       (pop_desc),
        .desc_valid (q_nonempty),
        .desc_pop   (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    // a closed frame always finds room in the queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("reply descriptor pushed into a full queue");

    // a reply is only taken from a queue that holds one
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_nonempty)
        else $error("reply descriptor popped from an empty queue");

    // a reply that directly follows a finished one starts with '#'
    a_reply_start: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
            (!m_axis_tvalid || m_axis_tdata == CH_HASH))
        else $error("reply does not open with '#'");

    // every reply closes on a newline
    a_reply_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == CH_NL))
        else $error("last reply character is not a newline");
`endif

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the ascii command frame handler.
// ----------------------------------------------------------------------------
// A queue of received characters is filled up front. It holds a few
// hand-picked frames and then randomly built frames: good frames, corrupted
// checksums, zero bytes, short, overlong and unterminated frames, and noise
// between frames. A clocked driver feeds that queue to the slave stream. A
// clocked monitor takes the reply characters off the master stream. Each
// accepted character runs through a parser model that queues the reply
// characters it should produce. Each reply character is checked against the
// oldest queued one.
// ----------------------------------------------------------------------------

module testbench;

    import acfh_pkg::*;

    localparam int MAX_FRAME      = 63;
    localparam int MAX_DATA       = 30;
    localparam int RANDOM_ITEMS   = 280;
    localparam int WATCHDOG_LIMIT = 1000;  // far above the longest gap plus a full reply stall
    localparam int END_WAIT       = 30;

    // characters the checksum reader cares about, beyond those in the package
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct {
        logic [7:0]        ch;
        logic [TEMP_W-1:0] temp;
        bit                drain;   // hold this character back until all replies are in
    } rx_item_t;

    typedef struct {
        logic [7:0] ch;
        logic       eol;
    } tx_char_t;

    logic clk;
    logic rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;     // rx_byte[7:0], current_temp[17:8], zero pad
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [7:0]  m_axis_tdata;           // tx_byte[7:0]
    wire         m_axis_tlast;

    wire rx_fire = s_axis_tvalid && s_axis_tready;
    wire tx_fire = m_axis_tvalid && m_axis_tready;

    // characters waiting to be sent, and reply characters still owed by the block
    rx_item_t   rx_items [$];
    tx_char_t   reply_chars [$];
    logic [7:0] frame_buf [$];

    // parser model state
    int         rx_len;
    logic [7:0] rx_cmd;
    logic [7:0] rx_sum;
    logic [7:0] rx_tail [3];
    bit         rx_zero_seen;

    // driver and monitor state
    int       rx_gap;
    bit       rx_idle_on = 1'b1;
    bit       rx_accepted;
    int       tx_stall;
    bit       tx_idle_on = 1'b1;
    int       quiet_cycles;
    tx_char_t want;

    // bookkeeping for the summary
    int stim_bytes;
    int rx_count;
    int replies_checked;
    int mismatch_count;
    int n_temp, n_ack, n_err_f, n_err_s, n_err_i;

    ascii_command_frame_handler #(
        .MAX_FRAME (MAX_FRAME),
        .MAX_DATA  (MAX_DATA)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // checksum field read like atoi: blanks, one sign, then digits
    function automatic bit checksum_ok(logic [7:0] sum);
        int          i;
        int unsigned val;
        bit          neg;
        i = 0;
        val = 0;
        neg = 1'b0;
        while (i < 3 && is_blank(rx_tail[i]))
            i++;
        if (i < 3 && (rx_tail[i] == CH_PLUS || rx_tail[i] == CH_MINUS))
        begin
            neg = rx_tail[i] == CH_MINUS;
            i++;
        end
        while (i < 3 && rx_tail[i] >= CH_ZERO && rx_tail[i] <= CH_NINE)
        begin
            val = val * 10 + (rx_tail[i] - CH_ZERO);
            i++;
        end
        if (neg && val != 0)
            return 1'b0;
        return val == sum;
    endfunction

    function automatic void queue_char(logic [7:0] ch, logic eol);
        tx_char_t c;
        c.ch = ch;
        c.eol = eol;
        reply_chars.push_back(c);
    endfunction

    function automatic void queue_digits(int unsigned v);
        queue_char(CH_ZERO + 8'(v / 100 % 10), 1'b0);
        queue_char(CH_ZERO + 8'(v / 10 % 10), 1'b0);
        queue_char(CH_ZERO + 8'(v % 10), 1'b0);
    endfunction

    function automatic void clear_frame();
        rx_len = 0;
        rx_cmd = '0;
        rx_sum = '0;
        rx_tail[0] = '0;
        rx_tail[1] = '0;
        rx_tail[2] = '0;
        rx_zero_seen = 1'b0;
    endfunction

    // one accepted character in, reply characters queued when a frame closes
    task automatic take_rx_byte(input logic [7:0] c, input logic [TEMP_W-1:0] t);
        logic [7:0]  payload;
        logic [7:0]  code;
        bit          bad;
        reply_kind_t kind;
        int unsigned tv;
        if (rx_len == 0 && c != CH_HASH)
            return;
        if (c != CH_BANG)
        begin
            if (c == 8'h00)
                rx_zero_seen = 1'b1;
            if (rx_len == 1)
                rx_cmd = c;
            if (rx_len >= 1)
                rx_sum = rx_sum + c;
            rx_tail[0] = rx_tail[1];
            rx_tail[1] = rx_tail[2];
            rx_tail[2] = c;
        end
        rx_len++;
        if (c != CH_BANG && rx_len < MAX_FRAME)
            return;

        // the sum so far includes the checksum characters, take them back out
        payload = rx_sum - rx_tail[0] - rx_tail[1] - rx_tail[2];
        bad = rx_zero_seen || c != CH_BANG || rx_len < 6 || rx_len - 6 > MAX_DATA;
        if (bad)
            kind = KIND_ERR_F;
        else if (!checksum_ok(payload))
            kind = KIND_ERR_S;
        else if (rx_cmd == CH_UPPER_C)
            kind = KIND_TEMP;
        else if (rx_cmd == CH_UPPER_M || rx_cmd == CH_UPPER_S)
            kind = KIND_ACK;
        else
            kind = KIND_ERR_I;
        clear_frame();

        queue_char(CH_HASH, 1'b0);
        case (kind)
            KIND_TEMP:
            begin
                tv = (t > TEMP_MAX) ? TEMP_MAX : t;
                queue_char(CH_LOWER_C, 1'b0);
                queue_digits(tv);
                queue_digits((CH_LOWER_C + tv / 100 % 10 + tv / 10 % 10 + tv % 10) % 256);
                n_temp++;
            end
            default:
            begin
                case (kind)
                    KIND_ACK:   begin code = CH_LOWER_O; n_ack++;   end
                    KIND_ERR_F: begin code = CH_LOWER_F; n_err_f++; end
                    KIND_ERR_S: begin code = CH_LOWER_S; n_err_s++; end
                    default:    begin code = CH_LOWER_I; n_err_i++; end
                endcase
                queue_char(CH_UPPER_E, 1'b0);
                queue_char(code, 1'b0);
                queue_digits((CH_UPPER_E + code) % 256);
            end
        endcase
        queue_char(CH_BANG, 1'b0);
        queue_char(CH_NL, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------------

    function automatic logic [TEMP_W-1:0] rand_temp();
        if ($urandom_range(0, 7) == 0)
            return TEMP_W'($urandom_range(1000, 1023));   // above range, saturates
        return TEMP_W'($urandom_range(0, 999));
    endfunction

    function automatic void queue_byte(logic [7:0] ch, logic [TEMP_W-1:0] t, bit drain);
        rx_item_t item;
        item.ch = ch;
        item.temp = t;
        item.drain = drain;
        rx_items.push_back(item);
    endfunction

    function automatic void queue_text(string s, logic [TEMP_W-1:0] t, bit drain);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], t, drain && i == 0);
    endfunction

    // sends the built frame; now and then the sender first waits for all replies
    function automatic void queue_frame(bit counted);
        bit drain;
        drain = $urandom_range(0, 19) == 0;
        foreach (frame_buf[i])
            queue_byte(frame_buf[i], rand_temp(), drain && i == 0);
        if (counted)
            stim_bytes += frame_buf.size();
    endfunction

    function automatic logic [7:0] data_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_BANG);
        return c;
    endfunction

    // a character that stops the checksum reader
    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_BANG || (c >= CH_ZERO && c <= CH_NINE));
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(8, 13);
        return (r == 8) ? CH_SPACE : 8'(r);
    endfunction

    // three checksum characters for v, in the plain form or one atoi variant
    function automatic void append_checksum(logic [7:0] v);
        int unsigned w;
        logic [7:0]  d2, d1, d0;
        w = v;
        d2 = CH_ZERO + 8'(w / 100);
        d1 = CH_ZERO + 8'(w / 10 % 10);
        d0 = CH_ZERO + 8'(w % 10);
        case ($urandom_range(0, 9))
            6:
                if (w < 100)
                begin
                    frame_buf.push_back(blank_char());
                    frame_buf.push_back(d1);
                    frame_buf.push_back(d0);
                    return;
                end
            7:
                if (w < 100)
                begin
                    frame_buf.push_back(CH_PLUS);
                    frame_buf.push_back(d1);
                    frame_buf.push_back(d0);
                    return;
                end
            8:
                if (w < 10)
                begin
                    frame_buf.push_back(d0);
                    frame_buf.push_back(junk_char());
                    frame_buf.push_back(junk_char());
                    return;
                end
                else if (w < 100)
                begin
                    frame_buf.push_back(d1);
                    frame_buf.push_back(d0);
                    frame_buf.push_back(junk_char());
                    return;
                end
            9:
            begin
                if (w == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            frame_buf.push_back(CH_MINUS);
                            frame_buf.push_back(CH_ZERO);
                            frame_buf.push_back(CH_ZERO);
                        end
                        1:
                            repeat (3) frame_buf.push_back(blank_char());
                        default:
                        begin
                            frame_buf.push_back(CH_PLUS);
                            frame_buf.push_back(junk_char());
                            frame_buf.push_back(junk_char());
                        end
                    endcase
                end
                else
                begin
                    // a minus sign on a nonzero value never matches
                    frame_buf.push_back(CH_MINUS);
                    frame_buf.push_back(d1);
                    frame_buf.push_back(d0);
                end
                return;
            end
            default: ;
        endcase
        frame_buf.push_back(d2);
        frame_buf.push_back(d1);
        frame_buf.push_back(d0);
    endfunction

    // well-formed frame with lo..hi data characters, checksum wrong now and then
    function automatic void build_command_frame(int lo, int hi);
        logic [7:0] cmd;
        logic [7:0] sum;
        int         n;
        frame_buf.delete();
        case ($urandom_range(0, 7))
            0, 1, 2: cmd = CH_UPPER_C;
            3, 4:    cmd = CH_UPPER_M;
            5:       cmd = CH_UPPER_S;
            default: cmd = data_byte();
        endcase
        n = $urandom_range(lo, hi);
        frame_buf.push_back(CH_HASH);
        frame_buf.push_back(cmd);
        sum = cmd;
        repeat (n)
        begin
            frame_buf.push_back(data_byte());
            sum = sum + frame_buf[frame_buf.size() - 1];
        end
        if ($urandom_range(0, 7) == 0)
            sum = sum + 8'($urandom_range(1, 255));
        append_checksum(sum);
        frame_buf.push_back(CH_BANG);
    endfunction

    // ------------------------------------------------------------------------
    // driver: new data at the falling edge, transfers counted at the rising edge
    // ------------------------------------------------------------------------

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (s_axis_tvalid && !rx_accepted)
            ;   // transfer still pending, hold everything
        else if (rx_gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            rx_gap <= rx_gap - 1;
        end
        else if (rx_items.size() == 0)
            s_axis_tvalid <= 1'b0;
        else if (rx_items[0].drain && reply_chars.size() != 0)
            s_axis_tvalid <= 1'b0;   // pause until every owed reply has come out
        else
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {6'b0, rx_items[0].temp, rx_items[0].ch};
            rx_gap <= (rx_idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        end
    end

    // replies lag the closing character by the reply queue and the output register,
    // so the model never has to queue a reply in the same step the monitor needs it
    always @(posedge clk)
    begin
        rx_accepted <= rst_n && rx_fire;
        if (rst_n && rx_fire)
        begin
            take_rx_byte(s_axis_tdata[7:0], s_axis_tdata[8 +: TEMP_W]);
            void'(rx_items.pop_front());
            rx_count++;
            if ($urandom_range(0, 59) == 0)
                rx_idle_on = !rx_idle_on;   // switch between gappy and back-to-back stretches
        end
    end

    // ------------------------------------------------------------------------
    // monitor: ready changes at the falling edge, transfers checked at the rising edge
    // ------------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (tx_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            tx_stall <= tx_stall - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            tx_stall <= (tx_idle_on && $urandom_range(0, 3) == 0) ? gap_len() : 0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && tx_fire)
        begin
            if ($urandom_range(0, 39) == 0)
                tx_idle_on = !tx_idle_on;
            if (reply_chars.size() == 0)
            begin
                $display("%0t ns: unexpected reply transfer, expected none, actual tx_byte %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end
            else
            begin
                want = reply_chars.pop_front();
                if (m_axis_tdata !== want.ch)
                begin
                    $display("%0t ns: tx_byte mismatch, expected %h actual %h",
                             $time, want.ch, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.eol)
                begin
                    $display("%0t ns: last mismatch, expected %b actual %b",
                             $time, want.eol, m_axis_tlast);
                    mismatch_count++;
                end
                if (want.eol)
                    replies_checked++;
            end
        end
    end

    // watchdog: ends the run when neither side has moved for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_fire || tx_fire)
                quiet_cycles <= 0;
            else if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no transfer for %0d cycles, %0d reply characters owed",
                         $time, WATCHDOG_LIMIT, reply_chars.size());
                $display("Mismatches found");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------

    initial
    begin
        int kind;
        int iter;
        int r;
        int cut;

        clear_frame();

        // hand-picked cases
        queue_byte(8'h00, 10'h3FF, 1'b0);              // noise outside a frame
        queue_byte(8'hFF, 10'h000, 1'b0);
        queue_text("#C067!", 10'h3FF, 1'b0);           // temperature above range
        queue_text("#M077!", 10'd0, 1'b1);             // waits for the reply above
        queue_text("#X088!", 10'd512, 1'b0);           // unknown command
        queue_text("#S", 10'd7, 1'b0);                 // one data byte, blank before digits
        queue_byte(8'hFF, 10'd7, 1'b0);
        queue_text(" 82!", 10'd999, 1'b0);
        queue_text("#M-77!", 10'd1, 1'b0);             // negative checksum
        queue_text("#C!", 10'd5, 1'b0);                // too short
        queue_text("#C", 10'd300, 1'b0);               // zero byte inside the frame
        queue_byte(8'h00, 10'd300, 1'b0);
        queue_text("067!", 10'd300, 1'b0);

        // random frames, each kind forced once at the start
        stim_bytes = 0;
        iter = 0;
        while (stim_bytes < RANDOM_ITEMS)
        begin
            if (iter < 8)
                kind = iter;
            else
            begin
                r = $urandom_range(0, 99);
                kind = (r < 60) ? 0 : (r < 68) ? 1 : (r < 72) ? 2 : (r < 75) ? 3 :
                       (r < 80) ? 4 : (r < 87) ? 5 : (r < 95) ? 6 : 7;
            end
            case (kind)
                0:
                begin
                    build_command_frame(0, ($urandom_range(0, 9) == 0) ? MAX_DATA : 6);
                    queue_frame(1'b1);
                end
                1:
                begin
                    build_command_frame(0, 6);
                    frame_buf[$urandom_range(1, frame_buf.size() - 2)] = 8'h00;
                    queue_frame(1'b1);
                end
                2:
                begin
                    // too much data, still closed by a bang
                    build_command_frame(MAX_DATA + 1, MAX_DATA + 10);
                    queue_frame(1'b1);
                end
                3:
                begin
                    // no bang, frame closed by the length limit
                    frame_buf.delete();
                    frame_buf.push_back(CH_HASH);
                    repeat (MAX_FRAME - 1)
                    begin
                        r = $urandom_range(0, 255);
                        frame_buf.push_back((8'(r) == CH_BANG) ? CH_HASH : 8'(r));
                    end
                    queue_frame(1'b1);
                end
                4:
                begin
                    frame_buf.delete();
                    frame_buf.push_back(CH_HASH);
                    repeat ($urandom_range(0, 3))
                        frame_buf.push_back(data_byte());
                    frame_buf.push_back(CH_BANG);
                    queue_frame(1'b1);
                end
                5:
                begin
                    // anything goes, an early bang leaves the rest as noise
                    frame_buf.delete();
                    frame_buf.push_back(CH_HASH);
                    repeat ($urandom_range(1, 10))
                        frame_buf.push_back(8'($urandom_range(0, 255)));
                    frame_buf.push_back(CH_BANG);
                    queue_frame(1'b1);
                end
                6:
                begin
                    frame_buf.delete();
                    repeat ($urandom_range(1, 5))
                    begin
                        r = $urandom_range(0, 255);
                        frame_buf.push_back((8'(r) == CH_HASH) ? CH_BANG : 8'(r));
                    end
                    queue_frame(1'b0);
                end
                default:
                begin
                    // frame cut short, runs on into whatever follows
                    build_command_frame(0, 6);
                    cut = $urandom_range(1, frame_buf.size() - 2);
                    while (frame_buf.size() > cut)
                        void'(frame_buf.pop_back());
                    queue_frame(1'b1);
                end
            endcase
            iter++;
        end

        repeat (7) @(posedge clk);
        #0.5 rst_n = 1'b1;

        while (rx_items.size() != 0 || reply_chars.size() != 0)
            @(posedge clk);
        repeat (END_WAIT) @(posedge clk);

        $display("%0d characters sent, %0d replies checked (%0d temperature, %0d ack)",
                 rx_count, replies_checked, n_temp, n_ack);
        $display("error replies: %0d framing, %0d checksum, %0d unknown command",
                 n_err_f, n_err_s, n_err_i);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
hdl/acfh_pkg.sv
hdl/acfh_parse.sv
hdl/acfh_fifo.sv
hdl/acfh_reply.sv
hdl/ascii_command_frame_handler.sv
test/testbench.sv
